// ----- design/min_tracking_stack_defines.svh -----
// assertion macros used by the checker file
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define MTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("min stack check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define MTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("min stack check failed");

`endif

// ----- design/mts_pkg.sv -----
package mts_pkg;

  // stack geometry
  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;

  // request codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_MIN  = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // control sequencer states
  typedef enum logic {
    S_IDLE   = 1'b0,
    S_REFILL = 1'b1
  } state_t;

endpackage

// ----- design/mts_ram.sv -----
// simple dual-port ram: one write port, one read port with registered data
module mts_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/min_tracking_stack.sv -----
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+---------------------------------------------
// in_       | in        | in_valid/in_stall  | in_operation, in_value
// out_      | out       | out_valid/out_stall| out_result_value, out_current_min,
//           |           |                    | out_entry_count, out_status
//
// push, min read, refused or empty requests: the result is loaded into the output register as
// the request is taken. pop that leaves the stack non-empty: the new top entry comes back from the
// value and min rams in the cycle after the read is issued.
// rst_n (synchronous) empties the stack; ram contents are left as they are.
// a stalled result holds in the output register; the next request is taken once
// that register is free or drains in the same cycle.
module min_tracking_stack (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mts_pkg::OP_W-1:0]             in_operation,
  input  logic signed [mts_pkg::DATA_W-1:0]    in_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mts_pkg::DATA_W-1:0]    out_result_value,
  output logic signed [mts_pkg::DATA_W-1:0]    out_current_min,
  output logic [mts_pkg::CNT_W-1:0]            out_entry_count,
  output logic [mts_pkg::STAT_W-1:0]           out_status
);

  mts_pkg::state_t state_r, state_nxt;
  logic [mts_pkg::CNT_W-1:0] fill_r, fill_nxt;

  // cached copy of the top entry of both stacks
  logic signed [mts_pkg::DATA_W-1:0] top_val_r, top_val_nxt;
  logic signed [mts_pkg::DATA_W-1:0] top_min_r, top_min_nxt;

  // output register
  logic                              out_valid_r, out_valid_nxt;
  logic signed [mts_pkg::DATA_W-1:0] out_result_r, out_result_nxt;
  logic signed [mts_pkg::DATA_W-1:0] out_min_r, out_min_nxt;
  logic [mts_pkg::CNT_W-1:0]         out_count_r, out_count_nxt;
  mts_pkg::status_t                  out_status_r, out_status_nxt;

  // ram ports
  logic                              wr_en;
  logic [mts_pkg::ADDR_W-1:0]        wr_addr;
  logic [mts_pkg::ADDR_W-1:0]        rd_addr;
  logic [mts_pkg::DATA_W-1:0]        rd_val;
  logic [mts_pkg::DATA_W-1:0]        rd_min;

  logic                              out_free;
  logic                              in_fire;
  logic                              is_empty;
  logic                              is_full;
  logic signed [mts_pkg::DATA_W-1:0] push_min;
  logic signed [mts_pkg::DATA_W-1:0] cur_min;
  logic [mts_pkg::CNT_W-1:0]         fill_dec;
  logic [mts_pkg::CNT_W-1:0]         fill_m2;
  logic                              pop_refill;
  mts_pkg::op_t                      op;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != mts_pkg::S_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;
  assign op       = mts_pkg::op_t'(in_operation);

  // stack status and new minimum on push
  assign is_empty = (fill_r == '0);
  assign is_full  = (fill_r == mts_pkg::CNT_W'(mts_pkg::DEPTH));
  assign push_min = (is_empty || (in_value < top_min_r)) ? in_value : top_min_r;
  assign cur_min  = is_empty ? '0 : top_min_r;
  assign fill_dec = fill_r - mts_pkg::CNT_W'(1);
  assign fill_m2  = fill_r - mts_pkg::CNT_W'(2);

  // pop that needs the entry below the top reloaded from the rams
  assign pop_refill = in_fire && (op == mts_pkg::OP_POP) && (fill_r > mts_pkg::CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mts_pkg::S_IDLE: begin
        if (pop_refill) begin
          state_nxt = mts_pkg::S_REFILL;
        end
      end
      mts_pkg::S_REFILL: begin
        state_nxt = mts_pkg::S_IDLE;
      end
      default: begin
        state_nxt = mts_pkg::S_IDLE;
      end
    endcase
  end

  // datapath and output register loads
  always_comb begin
    fill_nxt       = fill_r;
    top_val_nxt    = top_val_r;
    top_min_nxt    = top_min_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_result_nxt = out_result_r;
    out_min_nxt    = out_min_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    wr_en          = 1'b0;
    wr_addr        = fill_r[mts_pkg::ADDR_W-1:0];
    rd_addr        = fill_m2[mts_pkg::ADDR_W-1:0];
    case (state_r)
      mts_pkg::S_IDLE: begin
        if (in_fire) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = '0;
          out_min_nxt    = cur_min;
          out_count_nxt  = fill_r;
          out_status_nxt = mts_pkg::STAT_OK;
          case (op)
            mts_pkg::OP_PUSH: begin
              if (is_full) begin
                out_status_nxt = mts_pkg::STAT_FULL;
              end else begin
                wr_en         = 1'b1;
                fill_nxt      = fill_r + mts_pkg::CNT_W'(1);
                top_val_nxt   = in_value;
                top_min_nxt   = push_min;
                out_min_nxt   = push_min;
                out_count_nxt = fill_r + mts_pkg::CNT_W'(1);
              end
            end
            mts_pkg::OP_POP: begin
              if (is_empty) begin
                out_status_nxt = mts_pkg::STAT_EMPTY;
              end else begin
                fill_nxt       = fill_dec;
                out_result_nxt = top_val_r;
                out_count_nxt  = fill_dec;
                out_min_nxt    = '0;
                // result completes once the new top is back from the rams
                if (fill_dec != '0) begin
                  out_valid_nxt = 1'b0;
                end
              end
            end
            mts_pkg::OP_MIN: begin
              if (is_empty) begin
                out_status_nxt = mts_pkg::STAT_EMPTY;
              end else begin
                out_result_nxt = top_min_r;
              end
            end
            default: begin
            end
          endcase
        end
      end
      mts_pkg::S_REFILL: begin
        top_val_nxt   = rd_val;
        top_min_nxt   = rd_min;
        out_min_nxt   = rd_min;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mts_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    top_val_r    <= top_val_nxt;
    top_min_r    <= top_min_nxt;
    out_result_r <= out_result_nxt;
    out_min_r    <= out_min_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  // value stack storage
  mts_ram #(
    .Width(mts_pkg::DATA_W),
    .Depth(mts_pkg::DEPTH)
  ) u_val_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(in_value),
    .rd_addr(rd_addr),
    .rd_data(rd_val)
  );

  // running minimum storage
  mts_ram #(
    .Width(mts_pkg::DATA_W),
    .Depth(mts_pkg::DEPTH)
  ) u_min_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(push_min),
    .rd_addr(rd_addr),
    .rd_data(rd_min)
  );

  assign out_valid        = out_valid_r;
  assign out_result_value = out_result_r;
  assign out_current_min  = out_min_r;
  assign out_entry_count  = out_count_r;
  assign out_status       = out_status_r;

endmodule

// ----- design/min_tracking_stack_chk.sv -----
`include "min_tracking_stack_defines.svh"

// port-level checks on the result stream
module min_tracking_stack_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [mts_pkg::DATA_W-1:0] out_result_value,
  input logic signed [mts_pkg::DATA_W-1:0] out_current_min,
  input logic [mts_pkg::CNT_W-1:0]         out_entry_count,
  input logic [mts_pkg::STAT_W-1:0]        out_status
);

  // a refused push only happens on a full stack
  `MTS_ASSERT_IMP(a_full_count, out_valid && (out_status == mts_pkg::STAT_FULL), out_entry_count == mts_pkg::CNT_W'(mts_pkg::DEPTH))

  // an empty report carries zero count, result and minimum
  `MTS_ASSERT_IMP(a_empty_zero, out_valid && (out_status == mts_pkg::STAT_EMPTY), (out_entry_count == '0) && (out_result_value == '0) && (out_current_min == '0))

  // an empty stack after a good transfer shows a zero minimum
  `MTS_ASSERT_IMP(a_ok_empty_min, out_valid && (out_status == mts_pkg::STAT_OK) && (out_entry_count == '0), out_current_min == '0)

  // a stalled result holds
  `MTS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_value) && $stable(out_current_min) && $stable(out_entry_count))

endmodule

bind min_tracking_stack min_tracking_stack_chk u_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_value(out_result_value),
  .out_current_min (out_current_min),
  .out_entry_count (out_entry_count),
  .out_status      (out_status)
);
